// File: design/tmec_pkg.sv
// types, constants and helpers shared by the time code codec
package tmec_pkg;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [31:0] NIBBLE_MASK  = 32'h0000_000F;
  localparam logic [31:0] US_PER_SEC   = 32'd1000000;
  localparam logic [31:0] QUARTER_UNIT = 32'd15625;
  localparam logic [31:0] MANT_BIAS    = 32'd16;
  localparam logic [31:0] MIN_UNIT_US  = 32'd62500;
  localparam int          EXP_COUNT    = 16;
  localparam int          MANT_COUNT   = 16;
  localparam int          SCALED_W     = 25;
  localparam int          NORM_W       = 19;
  localparam logic [32:0] TOP_LIMIT_US = 33'(MIN_UNIT_US) << EXP_COUNT;
  localparam logic [7:0]  CODE_MIN     = 8'h00;
  localparam logic [7:0]  CODE_MAX     = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] operand;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        clipped;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic        opcode;
    logic [3:0]  expo;
    logic        under;
    logic        over;
    logic [31:0] value;
  } stage_t;

  // (16 + a) * 1e6 for a mantissa nibble
  function automatic logic [SCALED_W-1:0] mant_scaled(input logic [3:0] mant);
    logic [31:0] prod;
    begin
      prod = (MANT_BIAS + 32'(mant)) * US_PER_SEC;
      return prod[SCALED_W-1:0];
    end
  endfunction

endpackage

// File: design/tmec_exp.sv
// first stage: exponent search for encoding, mantissa scaling for decoding
module tmec_exp (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  tmec_pkg::in_t   cmd,
  output tmec_pkg::stage_t stg
);
  import tmec_pkg::*;

  logic [EXP_COUNT-1:0] ge;
  logic [3:0]           expo_enc;
  logic                 over;
  stage_t               stg_next;

  always_comb begin
    for (int k = 0; k < EXP_COUNT; k++) begin
      ge[k] = {1'b0, cmd.operand} >= (33'(MIN_UNIT_US) << k);
    end
    expo_enc = '0;
    for (int k = 0; k < EXP_COUNT; k++) begin
      if (ge[k]) begin
        expo_enc = 4'(k);
      end
    end
    over = {1'b0, cmd.operand} >= TOP_LIMIT_US;
  end

  always_comb begin
    stg_next.valid  = take;
    stg_next.opcode = cmd.opcode;
    unique case (cmd.opcode)
      OP_DECODE: begin
        stg_next.expo  = cmd.operand[3:0];
        stg_next.under = 1'b0;
        stg_next.over  = 1'b0;
        stg_next.value = 32'(mant_scaled(cmd.operand[7:4]));
      end
      OP_ENCODE: begin
        stg_next.expo  = expo_enc;
        stg_next.under = ~ge[0];
        stg_next.over  = over;
        stg_next.value = cmd.operand;
      end
      default: begin
        stg_next.expo  = '0;
        stg_next.under = 1'b0;
        stg_next.over  = 1'b0;
        stg_next.value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid <= 1'b0;
    end else begin
      stg.valid <= stg_next.valid;
    end
    stg.opcode <= stg_next.opcode;
    stg.expo   <= stg_next.expo;
    stg.under  <= stg_next.under;
    stg.over   <= stg_next.over;
    stg.value  <= stg_next.value;
  end

endmodule

// File: design/tmec_norm.sv
// second stage: shift by the exponent in either direction
module tmec_norm (
  input  logic             clk,
  input  logic             rst,
  input  tmec_pkg::stage_t src,
  output tmec_pkg::stage_t stg
);
  import tmec_pkg::*;

  logic [39:0] dec_full;
  logic [33:0] enc_full;
  stage_t      stg_next;

  always_comb begin
    dec_full = {15'b0, src.value[SCALED_W-1:0]} << src.expo;
    enc_full = {src.value, 2'b00} >> src.expo;
    stg_next = src;
    unique case (src.opcode)
      OP_DECODE: stg_next.value = dec_full[39:8];
      OP_ENCODE: stg_next.value = 32'(enc_full[NORM_W-1:0]);
      default:   stg_next.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid <= 1'b0;
    end else begin
      stg.valid <= stg_next.valid;
    end
    stg.opcode <= stg_next.opcode;
    stg.expo   <= stg_next.expo;
    stg.under  <= stg_next.under;
    stg.over   <= stg_next.over;
    stg.value  <= stg_next.value;
  end

endmodule

// File: design/tmec_mant.sv
// third stage: mantissa compare, saturation and output register
module tmec_mant (
  input  logic             clk,
  input  logic             rst,
  input  tmec_pkg::stage_t src,
  output logic             done,
  output tmec_pkg::out_t   rsp
);
  import tmec_pkg::*;

  logic [3:0] mant;
  logic [7:0] code;
  out_t       rsp_next;

  always_comb begin
    mant = '0;
    for (int j = 1; j < MANT_COUNT; j++) begin
      if ({13'b0, src.value[NORM_W-1:0]} >= QUARTER_UNIT * (MANT_BIAS + 32'(j))) begin
        mant = 4'(j);
      end
    end
    code = {mant, src.expo};
  end

  always_comb begin
    unique case (src.opcode)
      OP_DECODE: begin
        rsp_next.result  = src.value;
        rsp_next.clipped = 1'b0;
      end
      OP_ENCODE: begin
        priority if (src.under) begin
          rsp_next.result  = 32'(CODE_MIN);
          rsp_next.clipped = 1'b1;
        end else if (src.over) begin
          rsp_next.result  = 32'(CODE_MAX);
          rsp_next.clipped = 1'b1;
        end else begin
          rsp_next.result  = 32'(code);
          rsp_next.clipped = 1'b0;
        end
      end
      default: begin
        rsp_next.result  = '0;
        rsp_next.clipped = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

// File: design/time_mantissa_exponent_codec.sv
// top level of the validity-time code to microseconds codec
//
// one command channel and one result channel
// a transaction is taken on the rising edge where start is high and busy is low;
// cmd.opcode selects decode (8-bit code in cmd.operand[7:0] to microseconds)
// or encode (microseconds in cmd.operand to code [mantissa:4, exponent:4])
// three register stages: exponent search / mantissa scale, exponent shift,
// mantissa compare with saturation into the output register
// done is high for one cycle with each rsp, once the command has passed the
// exponent, shift and output registers in turn
// one transaction per cycle sustained, every stage takes a new one each cycle
// busy is high only while rst is asserted
// reset clears the stage valid bits, so nothing in flight is delivered
// the receiver cannot stall: each result is shown for exactly one cycle
// encode saturates to code 0x00 below 62500 us and to 0xFF from 4096000000 us,
// both with rsp.clipped set; decode always leaves rsp.clipped low
module time_mantissa_exponent_codec (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tmec_pkg::in_t  cmd,
  output logic           done,
  output tmec_pkg::out_t rsp
);
  import tmec_pkg::*;

  logic   take;
  stage_t stg_exp;
  stage_t stg_norm;

  assign busy = rst;
  assign take = start & ~busy;

  tmec_exp u_exp (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .cmd  (cmd),
    .stg  (stg_exp)
  );

  tmec_norm u_norm (
    .clk (clk),
    .rst (rst),
    .src (stg_exp),
    .stg (stg_norm)
  );

  tmec_mant u_mant (
    .clk  (clk),
    .rst  (rst),
    .src  (stg_norm),
    .done (done),
    .rsp  (rsp)
  );

endmodule

// File: tb/testbench.sv
// testbench for the validity-time code codec: predicted results against the pipelined block
module testbench;
  import tmec_pkg::*;

  class time_code_tracker;
    out_t awaited_rsp[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return awaited_rsp.size();
    endfunction

    function out_t convert_time(input in_t item);
      out_t        r;
      logic [3:0]  mant;
      logic [3:0]  expo;
      logic [63:0] wide;
      logic [63:0] quot;
      logic [31:0] units;
      int          lead;
      int          i;
      r = '0;
      if (item.opcode == OP_DECODE) begin
        mant = item.operand[7:4];
        expo = item.operand[3:0];
        wide = (64'(mant) + 64'd16) * 64'd1000000;
        wide = wide << expo;
        r.result = wide[39:8];
      end else begin
        units = item.operand / 32'd62500;
        if (units == 32'd0) begin
          r.result  = 32'h0000_0000;
          r.clipped = 1'b1;
        end else begin
          lead = 0;
          for (i = 0; i < 32; i++) if (units[i]) lead = i;
          if (lead > 15) begin
            r.result  = 32'h0000_00FF;
            r.clipped = 1'b1;
          end else begin
            quot = (64'(item.operand) << 2) / (64'd15625 << lead);
            quot = quot - 64'd16;
            r.result  = {24'd0, quot[3:0], 4'(lead)};
            r.clipped = 1'b0;
          end
        end
      end
      return r;
    endfunction

    function void note(input in_t item);
      awaited_rsp.push_back(convert_time(item));
    endfunction

    task check(input out_t got);
      out_t want;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("result %0d clipped %0b with nothing outstanding",
                         got.result, got.clipped));
      end else begin
        want = awaited_rsp.pop_front();
        if (got.result !== want.result)
          report($sformatf("result %0d, expected %0d", got.result, want.result));
        if (got.clipped !== want.clipped)
          report($sformatf("clipped %0b, expected %0b", got.clipped, want.clipped));
      end
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  cmd   = '0;
  logic busy;
  logic done;
  out_t rsp;

  time_code_tracker tracker;

  time_mantissa_exponent_codec uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note(cmd);
      if (done) tracker.check(rsp);
    end
  end

  // one transaction, then an optional idle gap with junk on the command bus
  task automatic issue(input in_t item, input int idle_pct);
    start <= 1'b1;
    cmd   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= {1'($urandom), 32'($urandom)};
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic make_decode(output in_t item, input logic [31:0] operand);
    item.opcode  = OP_DECODE;
    item.operand = operand;
  endtask

  task automatic make_encode(output in_t item, input logic [31:0] operand);
    item.opcode  = OP_ENCODE;
    item.operand = operand;
  endtask

  task automatic random_item(output in_t item);
    logic [63:0] lo;
    logic [31:0] span;
    logic [3:0]  expo;
    in_t         probe;
    out_t        probe_rsp;
    int          offs;
    case ($urandom_range(0, 9))
      0, 1: make_decode(item, $urandom);
      2: make_encode(item, $urandom);
      3, 4: begin
        expo = 4'($urandom_range(0, 15));
        lo   = 64'd62500 << expo;
        span = 32'(lo - 64'd1);
        make_encode(item, 32'(lo) + $urandom_range(0, span));
      end
      5, 6: begin
        make_decode(probe, $urandom_range(0, 255));
        probe_rsp = tracker.convert_time(probe);
        offs = $urandom_range(0, 4) - 2;
        make_encode(item, probe_rsp.result + 32'(offs));
      end
      7: make_encode(item, $urandom_range(0, 62499));
      8: make_encode(item, 32'd4096000000 + $urandom_range(0, 198967295));
      default: make_encode(item, 32'd62500 + $urandom_range(0, 2000000));
    endcase
  endtask

  initial begin
    in_t  item;
    int   k;
    int   pct;
    int   waited;
    logic [31:0] directed_dec[8];
    logic [31:0] directed_enc[14];
    tracker = new();
    directed_dec = '{32'h0000_0000, 32'h0000_00FF, 32'h0000_000F, 32'h0000_00F0,
                     32'h0000_0008, 32'h0000_0009, 32'hFFFF_FF3C, 32'hFFFF_FFFF};
    directed_enc = '{32'd0, 32'd1, 32'd62499, 32'd62500, 32'd62501, 32'd124999,
                     32'd125000, 32'd1000000, 32'd3968000000, 32'd4095999999,
                     32'd4096000000, 32'hFFFF_FFFF, 32'd2047999999, 32'd128000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and saturation edges
    foreach (directed_dec[i]) begin
      make_decode(item, directed_dec[i]);
      issue(item, 0);
    end
    foreach (directed_enc[i]) begin
      make_encode(item, directed_enc[i]);
      issue(item, 0);
    end
    drain();

    // random phases: back to back, heavy sender gaps, light gaps
    for (k = 0; k < 1050; k++) begin
      if (k < 350) pct = 0;
      else if (k < 700) pct = 46;
      else pct = 18;
      if (k == 520) drain();
      random_item(item);
      issue(item, pct);
    end
    start <= 1'b0;

    waited = 0;
    @(posedge clk);
    while (tracker.pending() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
